### hdl/acuds_pkg.sv
// Shared types, codes and the dial character decoder for the ACU dial string sequencer.
// Used by acuds_step, the top level and the port checker. No dependencies.
`default_nettype none

package acuds_pkg;

  // Request kinds carried on the input tuser field.
  localparam logic [2:0] REQ_START  = 3'd0;
  localparam logic [2:0] REQ_CHAR   = 3'd1;
  localparam logic [2:0] REQ_TICK   = 3'd2;
  localparam logic [2:0] REQ_STATUS = 3'd3;
  localparam logic [2:0] REQ_CLOSE  = 3'd4;

  // Call phase codes.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DIAL = 2'd1;
  localparam logic [1:0] PH_CONN = 2'd2;
  localparam logic [1:0] PH_FAIL = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_BUSY = 2'd1;
  localparam logic [1:0] ERR_FAIL = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic CFG_PAUSE = 1'b0;
  localparam logic CFG_FLASH = 1'b1;
  localparam int unsigned TICK_W = 16;
  localparam logic [TICK_W-1:0] PAUSE_RST = 16'd240;
  localparam logic [TICK_W-1:0] FLASH_RST = 16'd60;

  // Stream widths (data fields byte padded).
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 16;

  // What a dial character asks for.
  typedef enum logic [1:0] {
    CK_DIGIT  = 2'd0,
    CK_PAUSE  = 2'd1,
    CK_FLASH  = 2'd2,
    CK_IGNORE = 2'd3
  } char_kind_t;

  typedef struct packed {
    char_kind_t kind;
    logic [3:0] code;
  } char_map_t;

  // Unit status lines as they come with an item.
  typedef struct packed {
    logic pnd;
    logic dss;
    logic acr;
    logic pwi;
    logic dlo;
    logic done;
  } status_t;

  // Per-line dialer state.
  typedef struct packed {
    logic [1:0]        phase;
    logic              req_lvl;
    logic              next_want;
    logic              await_done;
    logic [TICK_W-1:0] wait_cnt;
    logic              flashing;
  } line_state_t;

  // One result item.
  typedef struct packed {
    logic [1:0] error_code;
    logic [1:0] call_phase;
    logic       char_taken;
    logic       digit_strobe;
    logic [3:0] digit_code;
    logic       call_request;
  } result_t;

  // Map a dial character to a digit code or a special action.
  function automatic char_map_t map_char(input logic [7:0] c);
    char_map_t m;
    m.kind = CK_IGNORE;
    m.code = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      m.kind = CK_DIGIT;
      m.code = c[3:0];
    end else begin
      unique case (c)
        8'h2A, 8'h3A: begin m.kind = CK_DIGIT; m.code = 4'd10; end  // star
        8'h23, 8'h3B: begin m.kind = CK_DIGIT; m.code = 4'd11; end  // pound
        8'h65, 8'h3C: begin m.kind = CK_DIGIT; m.code = 4'd12; end  // end
        8'h77, 8'h3D: begin m.kind = CK_DIGIT; m.code = 4'd13; end  // wait
        8'h2D:        m.kind = CK_PAUSE;
        8'h66:        m.kind = CK_FLASH;
        default:      m.kind = CK_IGNORE;
      endcase
    end
    return m;
  endfunction

endpackage

`default_nettype wire

### hdl/acuds_step.sv
// Next-state and result logic of the dialer for one accepted item.
// Depends on acuds_pkg for types, codes and the character decoder.
`default_nettype none

module acuds_step (
  input  acuds_pkg::line_state_t        state_i,
  input  logic [2:0]                    req_type,
  input  logic [7:0]                    char_code,
  input  acuds_pkg::status_t            status,
  input  logic [acuds_pkg::TICK_W-1:0]  pause_ticks,
  input  logic [acuds_pkg::TICK_W-1:0]  flash_ticks,
  output acuds_pkg::line_state_t        state_nxt,
  output acuds_pkg::result_t            result
);

  acuds_pkg::char_map_t cmap;
  logic                 can_take;
  logic [acuds_pkg::TICK_W-1:0] wait_dec;

  assign cmap     = acuds_pkg::map_char(char_code);
  assign wait_dec = state_i.wait_cnt - acuds_pkg::TICK_W'(1);
  assign can_take = (state_i.phase == acuds_pkg::PH_DIAL) && state_i.next_want &&
                    !state_i.await_done && (state_i.wait_cnt == '0) && !state_i.flashing;

  // State update and result fields, chosen by request kind.
  always_comb begin
    state_nxt           = state_i;
    result.digit_code   = 4'd0;
    result.digit_strobe = 1'b0;
    result.char_taken   = 1'b0;
    result.error_code   = acuds_pkg::ERR_NONE;

    unique case (req_type)
      acuds_pkg::REQ_START: begin
        if (status.pwi || status.dlo || state_i.req_lvl) begin
          result.error_code = acuds_pkg::ERR_BUSY;
        end else begin
          state_nxt          = '0;
          state_nxt.req_lvl  = 1'b1;
          state_nxt.phase    = acuds_pkg::PH_DIAL;
        end
      end
      acuds_pkg::REQ_CHAR: begin
        if (can_take) begin
          result.char_taken = 1'b1;
          unique case (cmap.kind)
            acuds_pkg::CK_DIGIT: begin
              result.digit_code    = cmap.code;
              result.digit_strobe  = 1'b1;
              state_nxt.await_done = 1'b1;
              state_nxt.next_want  = 1'b0;
            end
            acuds_pkg::CK_PAUSE: state_nxt.wait_cnt = pause_ticks;
            acuds_pkg::CK_FLASH: begin
              // A zero flash length leaves call request up.
              if (flash_ticks != '0) begin
                state_nxt.flashing = 1'b1;
                state_nxt.req_lvl  = 1'b0;
                state_nxt.wait_cnt = flash_ticks;
              end
            end
            default: ;
          endcase
        end
      end
      acuds_pkg::REQ_TICK: begin
        if (state_i.wait_cnt != '0) begin
          state_nxt.wait_cnt = wait_dec;
          // The flash ends when the count runs out.
          if (wait_dec == '0 && state_i.flashing) begin
            state_nxt.flashing = 1'b0;
            state_nxt.req_lvl  = 1'b1;
          end
        end
      end
      acuds_pkg::REQ_STATUS: begin
        state_nxt.next_want = status.pnd;
        if (status.done) begin
          state_nxt.await_done = 1'b0;
        end
        if (state_i.phase == acuds_pkg::PH_DIAL && (status.pwi || status.acr || status.dss)) begin
          // Failure wins over the answer report.
          if (status.pwi || status.acr) begin
            state_nxt.phase   = acuds_pkg::PH_FAIL;
            result.error_code = acuds_pkg::ERR_FAIL;
          end else begin
            state_nxt.phase = acuds_pkg::PH_CONN;
          end
          if (state_i.flashing) begin
            state_nxt.req_lvl = 1'b1;
          end
          state_nxt.flashing   = 1'b0;
          state_nxt.wait_cnt   = '0;
          state_nxt.await_done = 1'b0;
        end
      end
      acuds_pkg::REQ_CLOSE: state_nxt = '0;
      default: ;
    endcase

    result.call_request = state_nxt.req_lvl;
    result.call_phase   = state_nxt.phase;
  end

endmodule

`default_nettype wire

### hdl/acu_dial_string_sequencer_top.sv
// Top level of the ACU dial string sequencer: stream ports, line state and output register.
// Depends on acuds_pkg and acuds_step.
`default_nettype none

// The block takes one item per clock and returns exactly one result item for it, in the
// cycle after the input transfer. The line state register and the result register are
// the only stages, so a new item is taken in every cycle while the result side keeps up;
// when the result register is full and not being taken, input stalls. Configuration
// writes are always ready and take effect on the next item. There is no clearing pass.

module acu_dial_string_sequencer_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // tdata: char_code[7:0], status_pnd[8], status_dss[9], status_acr[10], status_pwi[11],
  //        status_dlo[12], status_done[13], zero[15:14]
  input  logic [acuds_pkg::IN_DATA_W-1:0]     in_tdata,
  // tuser: req_type[2:0]
  input  logic [acuds_pkg::IN_USER_W-1:0]     in_tuser,
  // Result stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // tdata: call_request[0], digit_code[4:1], digit_strobe[5], char_taken[6],
  //        call_phase[8:7], error_code[10:9], zero[15:11]
  output logic [acuds_pkg::OUT_DATA_W-1:0]    out_tdata,
  // Configuration write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [acuds_pkg::TICK_W-1:0]        cfg_data
);

  acuds_pkg::line_state_t state_r, state_nxt;
  acuds_pkg::result_t     result, res_r;
  acuds_pkg::status_t     status;
  logic [acuds_pkg::TICK_W-1:0] pause_r, flash_r;
  logic                   out_valid_r;
  logic                   in_xfer;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  // Unpack the status lines from the input data.
  assign status.pnd  = in_tdata[8];
  assign status.dss  = in_tdata[9];
  assign status.acr  = in_tdata[10];
  assign status.pwi  = in_tdata[11];
  assign status.dlo  = in_tdata[12];
  assign status.done = in_tdata[13];

  acuds_step u_step (
    .state_i     (state_r),
    .req_type    (in_tuser),
    .char_code   (in_tdata[7:0]),
    .status      (status),
    .pause_ticks (pause_r),
    .flash_ticks (flash_r),
    .state_nxt   (state_nxt),
    .result      (result)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pause_r <= acuds_pkg::PAUSE_RST;
      flash_r <= acuds_pkg::FLASH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        acuds_pkg::CFG_PAUSE: pause_r <= cfg_data;
        acuds_pkg::CFG_FLASH: flash_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Line state advances on every input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_xfer) begin
      state_r <= state_nxt;
    end
  end

  // Result register: loaded on an input transfer, emptied by an output transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_r};

endmodule

`default_nettype wire

### hdl/acuds_checker.sv
// Port-level checker for the ACU dial string sequencer, bound to the top level.
// Depends on acuds_pkg for codes and widths.
`default_nettype none

module acuds_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [acuds_pkg::OUT_DATA_W-1:0] out_tdata
);

  // A stalled result holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A presented digit always consumes its character.
  a_strobe_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5] |-> out_tdata[6])
    else $error("digit strobe without char_taken");

  // No digit code shows without its strobe.
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[5] |-> out_tdata[4:1] == 4'd0)
    else $error("digit code without strobe");

  // A call failure report leaves the line in the failed phase.
  a_fail_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10:9] == acuds_pkg::ERR_FAIL |->
      out_tdata[8:7] == acuds_pkg::PH_FAIL)
    else $error("failure error outside failed phase");

  // A busy refusal answers a start, so it never consumes a character or shows a digit.
  a_busy_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10:9] == acuds_pkg::ERR_BUSY |->
      !out_tdata[6] && !out_tdata[5])
    else $error("busy refusal with a character transfer");

endmodule

bind acu_dial_string_sequencer_top acuds_checker u_acuds_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
